[rtl/rttt_pkg.sv]
`default_nettype none

package rttt_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int TIME_W = 16;
  localparam int REP_W = 16;
  localparam int REM_W = 17;
  localparam int MASK_W = 8;
  localparam int GRANT_W = 3;
  localparam logic [REP_W-1:0] MARKER_RST = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_UNREGISTER = 2'd1,
    CMD_TICK       = 2'd2
  } cmd_t;

  typedef struct packed {
    logic                    action;
    logic [REP_W-1:0]        repeats;
    logic [TIME_W-1:0]       reload;
    logic signed [REM_W-1:0] remaining;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic   fire;
    logic   free;
    entry_t wb;
  } tick_res_t;

endpackage

`default_nettype wire

[rtl/rttt_ram.sv]
`default_nettype none

module rttt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/rttt_slot_alu.sv]
`default_nettype none

module rttt_slot_alu
  import rttt_pkg::*;
(
  input  wire entry_t            cur,
  input  wire logic [TIME_W-1:0] period,
  input  wire logic [REP_W-1:0]  marker,
  output tick_res_t              res
);

  logic signed [REM_W-1:0] rem_new;
  logic                    expired;
  logic [REP_W-1:0]        rep_dec;

  always_comb begin
    rem_new = cur.remaining - $signed({1'b0, period});
    expired = rem_new[REM_W-1] | (rem_new == '0);
    rep_dec = (cur.repeats != marker) ? (cur.repeats - 16'd1) : cur.repeats;

    res.fire = expired & cur.action;
    res.free = expired & (rep_dec == '0);
    res.wb.action = cur.action;
    res.wb.reload = cur.reload;
    res.wb.repeats = expired ? rep_dec : cur.repeats;
    res.wb.remaining = expired ? $signed({1'b0, cur.reload}) : rem_new;
  end

endmodule

`default_nettype wire

[rtl/recurring_timeout_timer_table.sv]
// Timer table with SLOTS slots, driven by one command per input transfer.
// Input channel: in_valid/in_stall with cmd, reload_time, repeat_count,
// has_action, slot_index and period. Every command gives exactly one result
// transfer on out_valid/out_stall carrying register_ok, granted_slot,
// fired_mask and freed_mask.
// The configuration channel cfg_valid/cfg_ready writes the infinite repeat
// marker; cfg_ready is always high. Write it only while the table is idle.
// Unregister and unknown commands go straight to the result state. Register
// walks the used bits one slot per cycle. Tick visits every slot; an unused
// slot passes through the table read state only, a used slot through table
// read, then subtract and write back through the one slot unit.
// One command is in work at a time; in_stall is high until its result is in
// the output register. A waiting result does not block the next command,
// but a second finished result holds until out_stall drops.
// Reset clears all slots to free, sets the marker to 65535 and empties the
// output register.
`default_nettype none

module recurring_timeout_timer_table
  import rttt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_cmd,
  input  wire logic [TIME_W-1:0]   in_reload_time,
  input  wire logic [REP_W-1:0]    in_repeat_count,
  input  wire logic                in_has_action,
  input  wire logic signed [3:0]   in_slot_index,
  input  wire logic [TIME_W-1:0]   in_period,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_register_ok,
  output logic [GRANT_W-1:0]       out_granted_slot,
  output logic [MASK_W-1:0]        out_fired_mask,
  output logic [MASK_W-1:0]        out_freed_mask,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [REP_W-1:0]    cfg_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_REG     = 5'b00010,
    S_TICK_RD = 5'b00100,
    S_TICK_EX = 5'b01000,
    S_DONE    = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic [SLOTS-1:0]   used_r, used_nxt;
  logic [REP_W-1:0]   marker_r;
  logic               ok_r, ok_nxt;
  logic [GRANT_W-1:0] slot_r, slot_nxt;
  logic [MASK_W-1:0]  fired_r, fired_nxt;
  logic [MASK_W-1:0]  freed_r, freed_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_load;

  logic [TIME_W-1:0]  reload_r;
  logic [REP_W-1:0]   repeats_r;
  logic               action_r;
  logic [TIME_W-1:0]  period_r;

  logic               in_xfer;
  logic               k_last;
  logic               unreg_ok;
  logic [IDX_W-1:0]   unreg_idx;

  logic               ram_we;
  logic               ram_re;
  entry_t             ram_wd;
  entry_t             ram_rd;
  entry_t             reg_entry;
  tick_res_t          alu_res;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign k_last    = (32'(k_r) == SLOTS - 1);
  assign unreg_ok  = ~in_slot_index[3] & (32'(in_slot_index[2:0]) < SLOTS);
  assign unreg_idx = IDX_W'(in_slot_index[2:0]);

  always_comb begin
    reg_entry.action = action_r;
    reg_entry.repeats = repeats_r;
    reg_entry.reload = reload_r;
    reg_entry.remaining = $signed({1'b0, reload_r});
  end

  rttt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (k_r),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (k_r),
    .rd_data (ram_rd)
  );

  rttt_slot_alu u_alu (
    .cur    (ram_rd),
    .period (period_r),
    .marker (marker_r),
    .res    (alu_res)
  );

  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r;
    used_nxt = used_r;
    ok_nxt = ok_r;
    slot_nxt = slot_r;
    fired_nxt = fired_r;
    freed_nxt = freed_r;
    ram_we = 1'b0;
    ram_re = 1'b0;
    ram_wd = alu_res.wb;
    out_load = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          k_nxt = '0;
          ok_nxt = 1'b0;
          slot_nxt = '0;
          fired_nxt = '0;
          freed_nxt = '0;
          unique case (cmd_t'(in_cmd))
            CMD_REGISTER: state_nxt = S_REG;
            CMD_UNREGISTER: begin
              if (unreg_ok) begin
                used_nxt[unreg_idx] = 1'b0;
              end
              state_nxt = S_DONE;
            end
            CMD_TICK: state_nxt = S_TICK_RD;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_REG: begin
        if (!used_r[k_r]) begin
          ram_we = 1'b1;
          ram_wd = reg_entry;
          used_nxt[k_r] = 1'b1;
          ok_nxt = 1'b1;
          slot_nxt = GRANT_W'(k_r);
          state_nxt = S_DONE;
        end else if (k_last) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_TICK_RD: begin
        if (used_r[k_r]) begin
          ram_re = 1'b1;
          state_nxt = S_TICK_EX;
        end else if (k_last) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_TICK_EX: begin
        if (alu_res.free) begin
          used_nxt[k_r] = 1'b0;
          freed_nxt = freed_r | (MASK_W'(1) << k_r);
        end else begin
          ram_we = 1'b1;
        end
        if (alu_res.fire) begin
          fired_nxt = fired_r | (MASK_W'(1) << k_r);
        end
        if (k_last) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt = k_r + 1'b1;
          state_nxt = S_TICK_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r <= '0;
      marker_r <= MARKER_RST;
      out_valid_r <= 1'b0;
      k_r <= '0;
    end else begin
      state_r <= state_nxt;
      used_r <= used_nxt;
      out_valid_r <= out_valid_nxt;
      k_r <= k_nxt;
      if (cfg_valid && cfg_ready) begin
        marker_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= ok_nxt;
    slot_r <= slot_nxt;
    fired_r <= fired_nxt;
    freed_r <= freed_nxt;
    if (in_xfer) begin
      reload_r <= in_reload_time;
      repeats_r <= in_repeat_count;
      action_r <= in_has_action;
      period_r <= in_period;
    end
    if (out_load) begin
      out_register_ok <= ok_r;
      out_granted_slot <= slot_r;
      out_fired_mask <= fired_r;
      out_freed_mask <= freed_r;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r != S_IDLE)
    else $error("table idle right after a command transfer");

  a_tick_slot_used: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TICK_EX |-> used_r[k_r])
    else $error("tick update on a free slot");

  a_masks_not_register: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_fired_mask != '0 || out_freed_mask != '0) |-> !out_register_ok)
    else $error("tick masks and register grant in one result");

  a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_register_ok |-> out_granted_slot == '0)
    else $error("granted slot set without a grant");

  a_ram_ports: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("table read and write in the same cycle");

endmodule

`default_nettype wire
